// ===== hdl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg
// shared request and result codes, and the controller/datapath interface types
// for the software timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

    typedef enum logic [2:0] {
        REQ_TICK         = 3'd0,
        REQ_ARM_NOTIFY   = 3'd1,
        REQ_STOP_NOTIFY  = 3'd2,
        REQ_ARM_PLAIN    = 3'd3,
        REQ_STOP_PLAIN   = 3'd4,
        REQ_READ_NOTIFY  = 3'd5,
        REQ_READ_PLAIN   = 3'd6,
        REQ_READ_TICKS   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_ACK   = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic tick_inc;
        logic idx_clr;
        logic exec;
        logic step;
        logic emit_done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic out_free;
        logic step_ok;
        logic idx_last;
    } t_stat;

endpackage

// ===== hdl/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank
// bank of countdown slots with a 64-bit tick counter; tick requests walk all
// slots and report expiries, other requests arm, stop or read
//
// channel   dir  tuser             tdata (low bit up)                   tlast
// s         in   req_type [2:0]    slot_id, load_value, repeat, notify   -
// m         out  kind [1:0]        slot_out, value                       last
//
// tick: capture, start of the walk, one cycle per slot (NUM_TIMERS), then
// the done transaction
// other requests: capture and execute, result valid the cycle after execute
// a full result register stalls the walk at the next firing slot, and holds
// execute and the done transaction
// reset (synchronous, active low) clears all slots and the tick counter
// ----------------------------------------------------------------------------
module software_timer_bank #(
    parameter int NUM_TIMERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // slot_id[4:0], load_value[20:5], repeat_mode[21], notify[22]
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // slot_out[4:0], value[68:5]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    stb_pkg::t_cmd  cmd;
    stb_pkg::t_stat stat;
    logic [4:0]     out_slot;
    logic [63:0]    out_value;

    stb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_s_tuser),
        .i_id        (i_s_tdata[4:0]),
        .i_load      (i_s_tdata[20:5]),
        .i_rep       (i_s_tdata[21]),
        .i_rpt       (i_s_tdata[22]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_kind  (o_m_tuser),
        .o_out_slot  (out_slot),
        .o_out_value (out_value),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'd0, out_value, out_slot};

endmodule

// ===== hdl/stb_ctrl.sv =====
// ----------------------------------------------------------------------------
// stb_ctrl
// sequencer for the timer bank: request capture, single requests, and the
// slot walk of a tick
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  stb_pkg::t_stat i_stat,
    output stb_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_tick) begin
                    o_cmd.tick_inc = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = S_WALK;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/stb_dp.sv =====
// ----------------------------------------------------------------------------
// stb_dp
// timer bank datapath: slot state, tick counter, request registers, per-slot
// countdown update and the result register
// ----------------------------------------------------------------------------
module stb_dp #(
    parameter int NUM_TIMERS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_req,
    input  logic [4:0]     i_id,
    input  logic [15:0]    i_load,
    input  logic           i_rep,
    input  logic           i_rpt,
    input  stb_pkg::t_cmd  i_cmd,
    output stb_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_out_kind,
    output logic [4:0]     o_out_slot,
    output logic [63:0]    o_out_value,
    output logic           o_out_last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    stb_pkg::t_req r_req;
    logic [4:0]    r_id;
    logic [15:0]   r_load;
    logic          r_rep;
    logic          r_rpt;

    logic [63:0]   r_ticks;
    logic [15:0]   r_n_cnt [NUM_TIMERS];
    logic [15:0]   r_n_rld [NUM_TIMERS];
    logic          r_n_arm [NUM_TIMERS];
    logic          r_n_rep [NUM_TIMERS];
    logic          r_n_rpt [NUM_TIMERS];
    logic [15:0]   r_p_cnt [NUM_TIMERS];
    logic [15:0]   r_p_rld [NUM_TIMERS];
    logic          r_p_arm [NUM_TIMERS];

    logic [IDX_W-1:0] r_idx;

    logic          r_out_valid;
    stb_pkg::t_kind r_out_kind;
    logic [4:0]    r_out_slot;
    logic [63:0]   r_out_value;
    logic          r_out_last;

    logic [IDX_W-1:0] addr;
    logic          ok;
    logic          out_free;
    logic [15:0]   n_dec;
    logic [15:0]   p_dec;
    logic [15:0]   n_cnt_nx;
    logic          n_arm_nx;
    logic [15:0]   p_cnt_nx;
    logic          p_arm_nx;
    logic          fire;
    logic          emit;
    stb_pkg::t_kind n_kind;
    logic [4:0]    n_slot;
    logic [63:0]   n_value;
    logic          n_last;

    // walk pointer while a tick is in progress, addressed slot otherwise
    assign addr     = (r_req == stb_pkg::REQ_TICK) ? r_idx : r_id[IDX_W-1:0];
    assign ok       = {1'b0, r_id} < 6'(NUM_TIMERS);
    assign out_free = !r_out_valid || i_out_ready;

    // one tick applied to the slot under the walk pointer
    always_comb begin
        n_dec    = (r_n_cnt[addr] != 16'd0) ? r_n_cnt[addr] - 16'd1 : 16'd0;
        n_cnt_nx = r_n_cnt[addr];
        n_arm_nx = r_n_arm[addr];
        fire     = 1'b0;
        if (r_n_arm[addr]) begin
            n_cnt_nx = n_dec;
            if (n_dec == 16'd0) begin
                fire = r_n_rpt[addr];
                if (r_n_rep[addr]) begin
                    n_cnt_nx = r_n_rld[addr];
                end else begin
                    n_arm_nx = 1'b0;
                end
            end
        end
        p_dec    = (r_p_cnt[addr] != 16'd0) ? r_p_cnt[addr] - 16'd1 : 16'd0;
        p_cnt_nx = r_p_cnt[addr];
        p_arm_nx = r_p_arm[addr];
        if (r_p_arm[addr]) begin
            p_cnt_nx = p_dec;
            if (p_dec == 16'd0) begin
                p_arm_nx = 1'b0;
            end
        end
    end

    assign o_stat.is_tick  = (r_req == stb_pkg::REQ_TICK);
    assign o_stat.out_free = out_free;
    assign o_stat.step_ok  = out_free || !fire;
    assign o_stat.idx_last = (r_idx == IDX_W'(NUM_TIMERS - 1));

    // result selection
    always_comb begin
        emit    = 1'b0;
        n_kind  = stb_pkg::KIND_ACK;
        n_slot  = r_id;
        n_value = '0;
        n_last  = 1'b1;
        if (i_cmd.exec) begin
            emit = 1'b1;
            unique case (r_req)
                stb_pkg::REQ_READ_NOTIFY: begin
                    n_kind = stb_pkg::KIND_READ;
                    if (ok) begin
                        n_value = 64'(16'(r_n_rld[addr] - r_n_cnt[addr]));
                    end
                end
                stb_pkg::REQ_READ_PLAIN: begin
                    n_kind = stb_pkg::KIND_READ;
                    if (ok) begin
                        n_value = 64'(16'(r_p_rld[addr] - r_p_cnt[addr]));
                    end
                end
                stb_pkg::REQ_READ_TICKS: begin
                    n_kind  = stb_pkg::KIND_READ;
                    n_slot  = 5'd0;
                    n_value = r_ticks;
                end
                stb_pkg::REQ_TICK,
                stb_pkg::REQ_ARM_NOTIFY,
                stb_pkg::REQ_STOP_NOTIFY,
                stb_pkg::REQ_ARM_PLAIN,
                stb_pkg::REQ_STOP_PLAIN: begin
                    n_kind = stb_pkg::KIND_ACK;
                end
            endcase
        end else if (i_cmd.step) begin
            emit   = fire;
            n_kind = stb_pkg::KIND_FIRED;
            n_slot = 5'(r_idx);
            n_last = 1'b0;
        end else if (i_cmd.emit_done) begin
            emit   = 1'b1;
            n_kind = stb_pkg::KIND_DONE;
            n_slot = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= stb_pkg::t_req'(i_req);
            r_id   <= i_id;
            r_load <= i_load;
            r_rep  <= i_rep;
            r_rpt  <= i_rpt;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (emit) begin
            r_out_kind  <= n_kind;
            r_out_slot  <= n_slot;
            r_out_value <= n_value;
            r_out_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // slot state and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            for (int s = 0; s < NUM_TIMERS; s++) begin
                r_n_cnt[s] <= '0;
                r_n_rld[s] <= '0;
                r_n_arm[s] <= 1'b0;
                r_n_rep[s] <= 1'b0;
                r_n_rpt[s] <= 1'b0;
                r_p_cnt[s] <= '0;
                r_p_rld[s] <= '0;
                r_p_arm[s] <= 1'b0;
            end
        end else begin
            if (i_cmd.tick_inc) begin
                r_ticks <= r_ticks + 64'd1;
            end
            if (i_cmd.step) begin
                r_n_cnt[addr] <= n_cnt_nx;
                r_n_arm[addr] <= n_arm_nx;
                r_p_cnt[addr] <= p_cnt_nx;
                r_p_arm[addr] <= p_arm_nx;
            end else if (i_cmd.exec && ok) begin
                unique case (r_req)
                    stb_pkg::REQ_ARM_NOTIFY: begin
                        r_n_cnt[addr] <= r_load;
                        r_n_rld[addr] <= r_load;
                        r_n_arm[addr] <= 1'b1;
                        r_n_rep[addr] <= r_rep;
                        r_n_rpt[addr] <= r_rpt;
                    end
                    stb_pkg::REQ_STOP_NOTIFY: begin
                        r_n_arm[addr] <= 1'b0;
                        r_n_cnt[addr] <= '0;
                    end
                    stb_pkg::REQ_ARM_PLAIN: begin
                        r_p_cnt[addr] <= r_load;
                        r_p_rld[addr] <= r_load;
                        r_p_arm[addr] <= 1'b1;
                    end
                    stb_pkg::REQ_STOP_PLAIN: begin
                        r_p_arm[addr] <= 1'b0;
                        r_p_cnt[addr] <= '0;
                    end
                    stb_pkg::REQ_TICK,
                    stb_pkg::REQ_READ_NOTIFY,
                    stb_pkg::REQ_READ_PLAIN,
                    stb_pkg::REQ_READ_TICKS: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_slot  = r_out_slot;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

// ===== sim/tb_timer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_pkg
// result tracking for the software timer bank bench: a cycle-free model of the
// slots and the tick counter, and the ordered list of results the block still
// owes, checked one by one as they leave the master side
// ----------------------------------------------------------------------------
package tb_timer_pkg;
    import stb_pkg::*;

    localparam int SLOT_COUNT = 32;

    typedef struct {
        t_kind       kind;
        logic [4:0]  slot;
        logic [63:0] value;
        logic        last;
    } t_timer_event;

    class timer_event_tracker;
        logic [63:0]  tick_total;
        logic [15:0]  ntf_cnt [SLOT_COUNT];
        logic [15:0]  ntf_rld [SLOT_COUNT];
        logic         ntf_armed [SLOT_COUNT];
        logic         ntf_rep [SLOT_COUNT];
        logic         ntf_rpt [SLOT_COUNT];
        logic [15:0]  pln_cnt [SLOT_COUNT];
        logic [15:0]  pln_rld [SLOT_COUNT];
        logic         pln_armed [SLOT_COUNT];
        t_timer_event owed [$];
        int           mismatch_count;

        function new();
            tick_total = '0;
            mismatch_count = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                ntf_cnt[s] = '0;
                ntf_rld[s] = '0;
                ntf_armed[s] = 1'b0;
                ntf_rep[s] = 1'b0;
                ntf_rpt[s] = 1'b0;
                pln_cnt[s] = '0;
                pln_rld[s] = '0;
                pln_armed[s] = 1'b0;
            end
        endfunction

        function void push_event(t_kind k, logic [4:0] s, logic [63:0] v, logic l);
            t_timer_event ev;
            ev.kind = k;
            ev.slot = s;
            ev.value = v;
            ev.last = l;
            owed.push_back(ev);
        endfunction

        function void post_request(t_req req, logic [4:0] id, logic [15:0] load,
                                   logic rep, logic ntf);
            logic        in_range;
            logic        fired;
            logic [15:0] elapsed;
            in_range = (int'(id) < SLOT_COUNT);
            case (req)
                REQ_TICK: begin
                    tick_total = tick_total + 64'd1;
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        fired = 1'b0;
                        if (ntf_armed[s]) begin
                            if (ntf_cnt[s] != 16'd0) ntf_cnt[s] = ntf_cnt[s] - 16'd1;
                            if (ntf_cnt[s] == 16'd0) begin
                                if (ntf_rep[s]) begin
                                    ntf_cnt[s] = ntf_rld[s];
                                end else begin
                                    ntf_armed[s] = 1'b0;
                                    ntf_cnt[s] = '0;
                                end
                                fired = ntf_rpt[s];
                            end
                        end
                        if (pln_armed[s]) begin
                            if (pln_cnt[s] != 16'd0) pln_cnt[s] = pln_cnt[s] - 16'd1;
                            if (pln_cnt[s] == 16'd0) pln_armed[s] = 1'b0;
                        end
                        if (fired) push_event(KIND_FIRED, 5'(s), '0, 1'b0);
                    end
                    push_event(KIND_DONE, '0, '0, 1'b1);
                end
                REQ_ARM_NOTIFY: begin
                    if (in_range) begin
                        ntf_cnt[id] = load;
                        ntf_rld[id] = load;
                        ntf_armed[id] = 1'b1;
                        ntf_rep[id] = rep;
                        ntf_rpt[id] = ntf;
                    end
                    push_event(KIND_ACK, id, '0, 1'b1);
                end
                REQ_STOP_NOTIFY: begin
                    if (in_range) begin
                        ntf_armed[id] = 1'b0;
                        ntf_cnt[id] = '0;
                    end
                    push_event(KIND_ACK, id, '0, 1'b1);
                end
                REQ_ARM_PLAIN: begin
                    if (in_range) begin
                        pln_cnt[id] = load;
                        pln_rld[id] = load;
                        pln_armed[id] = 1'b1;
                    end
                    push_event(KIND_ACK, id, '0, 1'b1);
                end
                REQ_STOP_PLAIN: begin
                    if (in_range) begin
                        pln_armed[id] = 1'b0;
                        pln_cnt[id] = '0;
                    end
                    push_event(KIND_ACK, id, '0, 1'b1);
                end
                REQ_READ_NOTIFY: begin
                    elapsed = in_range ? ntf_rld[id] - ntf_cnt[id] : 16'd0;
                    push_event(KIND_READ, id, {48'd0, elapsed}, 1'b1);
                end
                REQ_READ_PLAIN: begin
                    elapsed = in_range ? pln_rld[id] - pln_cnt[id] : 16'd0;
                    push_event(KIND_READ, id, {48'd0, elapsed}, 1'b1);
                end
                default: begin
                    push_event(KIND_READ, '0, tick_total, 1'b1);
                end
            endcase
        endfunction

        function void match_event(t_kind k, logic [4:0] s, logic [63:0] v, logic l);
            t_timer_event want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result kind=%0d slot=%0d value=%h last=%b",
                         $time, k, s, v, l);
                mismatch_count++;
                return;
            end
            want = owed.pop_front();
            if (k !== want.kind || s !== want.slot || v !== want.value || l !== want.last) begin
                $display("%0t: result mismatch, expected kind=%0d slot=%0d value=%h last=%b",
                         $time, want.kind, want.slot, want.value, want.last);
                $display("%0t:                  actual kind=%0d slot=%0d value=%h last=%b",
                         $time, k, s, v, l);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// bench for the software timer bank: directed arm, stop, read and tick
// requests, a phase with every slot firing while the result side is held off,
// then random traffic with random gaps on both streams; every result
// transaction is checked in order against the tracker's model
// ----------------------------------------------------------------------------
module tb_top;
    import stb_pkg::*;
    import tb_timer_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_ITEMS   = 150;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // slot_id, load_value, repeat_mode, notify
    logic [2:0]  i_s_tuser  = '0;   // req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;         // slot_out, value
    logic [1:0]  o_m_tuser;         // kind
    logic        o_m_tlast;

    timer_event_tracker tracker;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit long_hold_req = 1'b0;
    int idle_cycles   = 0;

    software_timer_bank #(
        .NUM_TIMERS(SLOT_COUNT)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_req(t_req req, logic [4:0] id, logic [15:0] load,
                            logic rep, logic ntf);
        int gap;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {1'b0, ntf, rep, load, id};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.post_request(req, id, load, rep, ntf);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            gap = gap_length();
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_req();
        int          pick;
        t_req        req;
        logic [15:0] load;
        pick = $urandom_range(0, 99);
        if (pick < 35)      req = REQ_TICK;
        else if (pick < 50) req = REQ_ARM_NOTIFY;
        else if (pick < 60) req = REQ_ARM_PLAIN;
        else if (pick < 70) req = REQ_STOP_NOTIFY;
        else if (pick < 75) req = REQ_STOP_PLAIN;
        else if (pick < 84) req = REQ_READ_NOTIFY;
        else if (pick < 93) req = REQ_READ_PLAIN;
        else                req = REQ_READ_TICKS;
        case ($urandom_range(0, 9))
            0, 1: load = 16'($urandom_range(0, 65535));
            2, 3: load = 16'($urandom_range(5, 24));
            default: load = 16'($urandom_range(0, 4));
        endcase
        send_req(req, 5'($urandom_range(0, 31)), load, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 9) < 8);
    endtask

    // result side
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                i_m_tready <= 1'b0;
                stall_left = gap_length() - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                tracker.match_event(t_kind'(o_m_tuser), o_m_tdata[4:0], o_m_tdata[68:5],
                                    o_m_tlast);
            end
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        tracker = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_req(REQ_READ_TICKS,  5'd0,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_NOTIFY, 5'd0,  16'hffff, 1'b1, 1'b1);
        send_req(REQ_READ_PLAIN,  5'd31, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_ARM_NOTIFY,  5'd0,  16'h0000, 1'b1, 1'b1);
        send_req(REQ_ARM_NOTIFY,  5'd31, 16'h0001, 1'b0, 1'b1);
        send_req(REQ_ARM_NOTIFY,  5'd15, 16'hffff, 1'b1, 1'b1);
        send_req(REQ_ARM_PLAIN,   5'd5,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_ARM_PLAIN,   5'd31, 16'hffff, 1'b1, 1'b1);
        send_req(REQ_ARM_NOTIFY,  5'd7,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_TICK,        5'd31, 16'hffff, 1'b1, 1'b1);
        send_req(REQ_TICK,        5'd0,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_NOTIFY, 5'd31, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_NOTIFY, 5'd15, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_PLAIN,  5'd31, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_PLAIN,  5'd5,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_STOP_NOTIFY, 5'd15, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_NOTIFY, 5'd15, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_STOP_PLAIN,  5'd31, 16'hffff, 1'b1, 1'b1);
        send_req(REQ_READ_PLAIN,  5'd31, 16'h0000, 1'b0, 1'b0);
        send_req(REQ_ARM_NOTIFY,  5'd20, 16'h0002, 1'b1, 1'b1);
        send_req(REQ_TICK,        5'd0,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_TICK,        5'd0,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_TICK,        5'd0,  16'h0000, 1'b0, 1'b0);
        send_req(REQ_READ_TICKS,  5'd31, 16'hffff, 1'b1, 1'b1);
        send_req(REQ_STOP_NOTIFY, 5'd0,  16'h0000, 1'b0, 1'b0);
        drain();

        // every slot fires on each tick while the result side is held off
        sink_idle_pct = 30;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            send_req(REQ_ARM_NOTIFY, 5'(s), 16'h0000, 1'b1, 1'b1);
        end
        long_hold_req = 1'b1;
        repeat (6) begin
            send_req(REQ_TICK, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 15;
                    default: src_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_idle_pct = 0;
                    1: sink_idle_pct = 15;
                    default: sink_idle_pct = 40;
                endcase
            end
            if (n == RANDOM_ITEMS / 2) drain();
            send_random_req();
        end
        drain();

        sink_idle_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
